/* hdl/mts_pkg.sv */
package mts_pkg;

    // default geometry
    localparam int MTS_DEPTH      = 256;
    localparam int MTS_DATA_WIDTH = 32;

    // action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

endpackage

/* hdl/mts_ram.sv */
module mts_ram #(
    parameter int DEPTH = mts_pkg::MTS_DEPTH,
    parameter int WIDTH = 2 * mts_pkg::MTS_DATA_WIDTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/min_tracking_stack_top.sv */
// a push, failed push or failed pop shows its transaction in the cycle after acceptance; a pop that
// leaves entries below it first reads the entry memory (state ST_LOAD), then registers its result.
// throughput: one push per cycle while the output is not stalled; a pop that uncovers an entry holds
// the input in ST_LOAD. The top entry and its minimum sit in registers, the rest in one memory with
// registered reads. reset: entry count and top registers clear to zero; memory contents are not reset.
module min_tracking_stack_top #(
    parameter int DEPTH      = mts_pkg::MTS_DEPTH,
    parameter int DATA_WIDTH = mts_pkg::MTS_DATA_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic signed [DATA_WIDTH-1:0]   value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [DATA_WIDTH-1:0]   min_value,
    output logic signed [DATA_WIDTH-1:0]   top_value,
    output logic [$clog2(DEPTH+1)-1:0]     count,
    output logic                           empty_res,
    output logic [1:0]                     error
);

    import mts_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = 2 * DATA_WIDTH;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOAD = 1'b1;

    logic                         state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic signed [DATA_WIDTH-1:0] top_val_reg, top_val_next;
    logic signed [DATA_WIDTH-1:0] top_min_reg, top_min_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] min_value_reg, min_value_next;
    logic signed [DATA_WIDTH-1:0] top_value_reg, top_value_next;
    logic [CW-1:0]                count_out_reg, count_out_next;
    logic                         empty_reg, empty_next;
    logic [1:0]                   error_reg, error_next;

    logic                         accept;
    logic                         produce;
    logic [1:0]                   err_code;
    logic signed [DATA_WIDTH-1:0] push_min;
    logic                         wr_en;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [EW-1:0]                rd_data;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // new running minimum for a push
    assign push_min = (count_reg == '0 || value < top_min_reg) ? value : top_min_reg;

    // entry memory: {min, value} per slot
    mts_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({push_min, value}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // stack control
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_val_next = top_val_reg;
        top_min_next = top_min_reg;
        produce      = 1'b0;
        err_code     = ERR_NONE;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = AW'(count_reg - CW'(2));

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_PUSH)
                    begin
                        produce = 1'b1;
                        if (count_reg == CW'(DEPTH))
                        begin
                            err_code = ERR_FULL;
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            count_next   = count_reg + CW'(1);
                            top_val_next = value;
                            top_min_next = push_min;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            produce  = 1'b1;
                            err_code = ERR_EMPTY;
                        end
                        else if (count_reg == CW'(1))
                        begin
                            produce      = 1'b1;
                            count_next   = '0;
                            top_val_next = '0;
                            top_min_next = '0;
                        end
                        else
                        begin
                            // uncover the entry below: fetch it from memory
                            count_next = count_reg - CW'(1);
                            rd_en      = 1'b1;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                produce      = 1'b1;
                top_val_next = rd_data[DATA_WIDTH-1:0];
                top_min_next = rd_data[EW-1:DATA_WIDTH];
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        min_value_next = min_value_reg;
        top_value_next = top_value_reg;
        count_out_next = count_out_reg;
        empty_next     = empty_reg;
        error_next     = error_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
            min_value_next = top_min_next;
            top_value_next = top_val_next;
            count_out_next = count_next;
            empty_next     = (count_next == '0);
            error_next     = err_code;
        end
    end

    // control and top-of-stack registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            top_val_reg   <= '0;
            top_min_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            top_val_reg   <= top_val_next;
            top_min_reg   <= top_min_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        min_value_reg <= min_value_next;
        top_value_reg <= top_value_next;
        count_out_reg <= count_out_next;
        empty_reg     <= empty_next;
        error_reg     <= error_next;
    end

    assign out_valid = out_valid_reg;
    assign min_value = min_value_reg;
    assign top_value = top_value_reg;
    assign count     = count_out_reg;
    assign empty_res = empty_reg;
    assign error     = error_reg;

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

    import mts_pkg::*;

    localparam int DEPTH      = MTS_DEPTH;
    localparam int DW         = MTS_DATA_WIDTH;
    localparam int CW         = $clog2(MTS_DEPTH + 1);
    localparam int QUIET_TAIL = 80;
    localparam int HOLD_OFF   = 80;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 10;

    // one push or pop as offered to the stack
    typedef struct {
        logic                 act;
        logic signed [DW-1:0] val;
        bit                   wait_drain;
    } stack_op_t;

    // stack status reported for one transaction
    typedef struct {
        logic signed [DW-1:0] min_value;
        logic signed [DW-1:0] top_value;
        logic [CW-1:0]        count;
        logic                 empty_res;
        logic [1:0]           error;
    } stack_status_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 action    = ACT_PUSH;
    logic signed [DW-1:0] value     = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [DW-1:0] min_value;
    logic signed [DW-1:0] top_value;
    logic [CW-1:0]        count;
    logic                 empty_res;
    logic [1:0]           error;

    // pending pushes and pops, and the status each accepted one must produce
    stack_op_t     pending_ops[$];
    stack_status_t expected_status[$];
    stack_status_t want_status;

    // predicted stack contents
    logic signed [DW-1:0] shadow_value [DEPTH];
    logic signed [DW-1:0] shadow_min [DEPTH];
    int                   shadow_depth = 0;

    int total_ops      = 0;
    int ops_sent       = 0;
    int ops_accepted   = 0;
    int mismatch_count = 0;
    int plan_depth     = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit in_fire        = 1'b0;
    int idle_cycles    = 0;

    min_tracking_stack_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .min_value (min_value),
        .top_value (top_value),
        .count     (count),
        .empty_res (empty_res),
        .error     (error)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // apply one push or pop to the shadow stack and return the status it reports
    function automatic stack_status_t apply_stack_op(input logic act,
                                                     input logic signed [DW-1:0] val);
        stack_status_t        st;
        logic signed [DW-1:0] run_min;
        st.error = ERR_NONE;
        if (act == ACT_PUSH)
        begin
            if (shadow_depth >= DEPTH)
                st.error = ERR_FULL;
            else
            begin
                run_min = val;
                if (shadow_depth > 0 && !(val < shadow_min[shadow_depth-1]))
                    run_min = shadow_min[shadow_depth-1];
                shadow_value[shadow_depth] = val;
                shadow_min[shadow_depth]   = run_min;
                shadow_depth++;
            end
        end
        else if (shadow_depth == 0)
            st.error = ERR_EMPTY;
        else
            shadow_depth--;
        if (shadow_depth > 0)
        begin
            st.min_value = shadow_min[shadow_depth-1];
            st.top_value = shadow_value[shadow_depth-1];
        end
        else
        begin
            st.min_value = '0;
            st.top_value = '0;
        end
        st.count     = shadow_depth[CW-1:0];
        st.empty_res = (shadow_depth == 0);
        return st;
    endfunction

    task automatic check_field(input string name, input logic [DW-1:0] want,
                               input logic [DW-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%h, got 0x%h", name, want, got);
            mismatch_count++;
        end
    endtask

    // queue one operation, tracking the depth the stack will have after it
    task automatic plan_op(input logic act, input logic signed [DW-1:0] val,
                           input bit wait_drain);
        stack_op_t op;
        op.act        = act;
        op.val        = val;
        op.wait_drain = wait_drain;
        pending_ops.push_back(op);
        if (act == ACT_PUSH && plan_depth < DEPTH)
            plan_depth++;
        else if (act == ACT_POP && plan_depth > 0)
            plan_depth--;
    endtask

    // values biased toward extremes and small numbers so ties happen often
    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(DW-1){1'b1}}};
            1:       return {1'b1, {(DW-1){1'b0}}};
            2, 3:    return $signed($urandom_range(0, 20)) - 10;
            default: return $urandom;
        endcase
    endfunction

    // sender: offers queued transactions at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
            ;
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (pending_ops.size() == 0)
            in_valid <= 1'b0;
        else if (pending_ops[0].wait_drain && expected_status.size() != 0)
            in_valid <= 1'b0;
        else
        begin
            in_valid <= 1'b1;
            action   <= pending_ops[0].act;
            value    <= pending_ops[0].val;
            void'(pending_ops.pop_front());
            ops_sent++;
            if (ops_sent < total_ops - QUIET_TAIL && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 10);
        end
    end

    // receiver: random stalls plus one long hold-off that backs up the stack
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && ops_accepted >= 40)
        begin
            out_ready <= 1'b0;
            hold_done = 1'b1;
            hold_left = HOLD_OFF - 1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (ops_accepted < total_ops - QUIET_TAIL && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(0, 9);
        end
        else
            out_ready <= 1'b1;
    end

    // monitor: check each result, then predict for each accepted transaction
    always @(posedge clk)
    begin
        in_fire <= in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                $error("result transaction arrived with nothing pending");
                mismatch_count++;
            end
            else
            begin
                want_status = expected_status.pop_front();
                check_field("min_value", want_status.min_value, min_value);
                check_field("top_value", want_status.top_value, top_value);
                check_field("count", DW'(want_status.count), DW'(count));
                check_field("empty_res", DW'(want_status.empty_res), DW'(empty_res));
                check_field("error", DW'(want_status.error), DW'(error));
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            expected_status.push_back(apply_stack_op(action, value));
            ops_accepted++;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        // directed: empty pops, extremes, ties, uncovering older minima
        plan_op(ACT_POP, '0, 1'b0);
        plan_op(ACT_PUSH, '0, 1'b0);
        plan_op(ACT_PUSH, 32'sh7FFF_FFFF, 1'b0);
        plan_op(ACT_PUSH, 32'sh8000_0000, 1'b0);
        plan_op(ACT_PUSH, 32'sh8000_0000, 1'b0);
        plan_op(ACT_POP, 32'sh5555_5555, 1'b0);
        plan_op(ACT_POP, '0, 1'b0);
        plan_op(ACT_PUSH, -1, 1'b0);
        plan_op(ACT_PUSH, 32'sh5555_5555, 1'b0);
        plan_op(ACT_PUSH, 32'shAAAA_AAAA, 1'b0);
        plan_op(ACT_POP, '0, 1'b0);
        plan_op(ACT_POP, '0, 1'b0);
        plan_op(ACT_POP, '0, 1'b0);
        plan_op(ACT_POP, '0, 1'b0);
        plan_op(ACT_POP, '1, 1'b0);
        plan_op(ACT_PUSH, 32'sh7FFF_FFFF, 1'b0);
        plan_op(ACT_PUSH, 32'sh7FFF_FFFF, 1'b0);
        plan_op(ACT_POP, '0, 1'b0);
        plan_op(ACT_POP, '0, 1'b0);
        plan_op(ACT_PUSH, 1, 1'b0);
        plan_op(ACT_PUSH, 1, 1'b0);
        plan_op(ACT_PUSH, 0, 1'b0);
        plan_op(ACT_POP, '0, 1'b0);
        plan_op(ACT_POP, '0, 1'b0);
        plan_op(ACT_POP, '0, 1'b0);

        // fill to capacity, then push onto the full stack
        while (plan_depth < DEPTH)
            plan_op(ACT_PUSH, pick_value(), 1'b0);
        repeat (3)
            plan_op(ACT_PUSH, pick_value(), 1'b0);

        // random walk from the full stack
        repeat (120)
            plan_op(logic'($urandom_range(0, 1)), pick_value(), 1'b0);

        // drain to empty after the sender waits for all results, then over-pop
        plan_op(ACT_POP, pick_value(), 1'b1);
        while (plan_depth > 0)
            plan_op(ACT_POP, pick_value(), 1'b0);
        repeat (2)
            plan_op(ACT_POP, pick_value(), 1'b0);

        // shallow random mix that keeps hitting the empty stack
        repeat (60)
            plan_op(logic'($urandom_range(0, 1)), pick_value(), 1'b0);

        total_ops = pending_ops.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (ops_accepted < total_ops)
            @(posedge clk);
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
